>>> sv/sstf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sstf_pkg
// shared sizes, codes and types of the nearest-seek request scheduler
// ---------------------------------------------------------------------------
package sstf_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int SECTOR_BITS = 48;
    localparam int TAG_BITS    = 8;

    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_BITS   = SECTOR_BITS + TAG_BITS;

    localparam int CMDQ_DEPTH    = 2;
    localparam int CMDQ_PTR_BITS = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_BITS = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_ADD      = 2'd0,
        FUNC_DISPATCH = 2'd1,
        FUNC_REMOVE   = 2'd2,
        FUNC_NOP      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } back_state_t;

    typedef struct packed {
        func_t                  func;
        logic [SECTOR_BITS-1:0] sector;
        logic [TAG_BITS-1:0]    tag;
    } cmd_t;

endpackage
`default_nettype wire

>>> sv/sstf_req_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sstf_req_if
// request channel: command, sector and tag with valid/ready
// ---------------------------------------------------------------------------
interface sstf_req_if;

    logic                           valid;
    logic                           ready;
    logic [1:0]                     func;
    logic [sstf_pkg::SECTOR_BITS-1:0] sector;
    logic [sstf_pkg::TAG_BITS-1:0]    tag;

    modport source (output valid, output func, output sector, output tag, input ready);
    modport sink   (input valid, input func, input sector, input tag, output ready);

endinterface
`default_nettype wire

>>> sv/sstf_rsp_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sstf_rsp_if
// response channel: status, sector and tag with valid/ready
// ---------------------------------------------------------------------------
interface sstf_rsp_if;

    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [sstf_pkg::SECTOR_BITS-1:0] out_sector;
    logic [sstf_pkg::TAG_BITS-1:0]    out_tag;

    modport source (output valid, output status, output out_sector, output out_tag,
                    input ready);
    modport sink   (input valid, input status, input out_sector, input out_tag,
                    output ready);

endinterface
`default_nettype wire

>>> sv/sstf_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sstf_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module sstf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

>>> sv/sstf_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sstf_front
// accepts requests, decodes the command and queues it for the scan engine
// ---------------------------------------------------------------------------
module sstf_front (
    input  logic           clk,
    input  logic           rst_n,
    sstf_req_if.sink       req,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output sstf_pkg::cmd_t cmd
);
    import sstf_pkg::*;

    cmd_t                     q_mem_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_BITS-1:0] count_reg, count_next;
    logic                     push, pop;
    cmd_t                     in_cmd;

    assign req.ready = (count_reg != CMDQ_CNT_BITS'(CMDQ_DEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_cmd.func   = func_t'(req.func);
        in_cmd.sector = req.sector;
        in_cmd.tag    = req.tag;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_BITS'(CMDQ_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_BITS'(CMDQ_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

>>> sv/sstf_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sstf_back
// scan engine: walks all slots once per add, remove or dispatch, picks the slot, commits
// ---------------------------------------------------------------------------
module sstf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  sstf_pkg::cmd_t cmd,
    sstf_rsp_if.source     rsp
);
    import sstf_pkg::*;

    back_state_t            state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [SECTOR_BITS-1:0] head_reg, head_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_BITS-1:0]    rd_cnt_reg, rd_cnt_next;

    logic                   p0_act_reg, p0_act_next;
    logic [IDX_BITS-1:0]    p0_idx_reg, p0_idx_next;
    logic                   p0_live_reg, p0_live_next;

    logic                   p1_act_reg, p1_act_next;
    logic [IDX_BITS-1:0]    p1_idx_reg, p1_idx_next;
    logic                   p1_live_reg, p1_live_next;
    logic [SECTOR_BITS-1:0] p1_dist_reg, p1_dist_next;
    logic [SECTOR_BITS-1:0] p1_sector_reg, p1_sector_next;
    logic [TAG_BITS-1:0]    p1_tag_reg, p1_tag_next;

    logic                   found_reg, found_next;
    logic [IDX_BITS-1:0]    best_idx_reg, best_idx_next;
    logic [SECTOR_BITS-1:0] best_dist_reg, best_dist_next;
    logic [SECTOR_BITS-1:0] best_sector_reg, best_sector_next;
    logic [TAG_BITS-1:0]    best_tag_reg, best_tag_next;

    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [SECTOR_BITS-1:0] out_sector_reg, out_sector_next;
    logic [TAG_BITS-1:0]    out_tag_reg, out_tag_next;

    logic                   out_free;
    logic                   issue;
    logic                   commit;
    logic                   scan_done;
    logic                   better;
    logic                   take;
    logic                   ram_we;
    logic [SLOT_BITS-1:0]   ram_rdata;
    logic [SECTOR_BITS-1:0] rd_sector;
    logic [TAG_BITS-1:0]    rd_tag;

    sstf_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (best_idx_reg),
        .wdata ({cmd_reg.sector, cmd_reg.tag}),
        .raddr (rd_cnt_reg[IDX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_sector = ram_rdata[SLOT_BITS-1:TAG_BITS];
    assign rd_tag    = ram_rdata[TAG_BITS-1:0];
    assign out_free  = !out_valid_reg || rsp.ready;
    assign scan_done = (rd_cnt_reg == CNT_BITS'(QUEUE_DEPTH)) && !p0_act_reg && !p1_act_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd.func == FUNC_NOP) ? BK_FINISH : BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        issue     = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            BK_SCAN:
            begin
                issue = (rd_cnt_reg != CNT_BITS'(QUEUE_DEPTH));
            end
            BK_FINISH:
            begin
                commit = out_free;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign ram_we = commit && (cmd_reg.func == FUNC_ADD) && found_reg;

    // candidate selection
    always_comb
    begin
        better = !found_reg || (p1_dist_reg < best_dist_reg)
              || ((p1_dist_reg == best_dist_reg) && (p1_sector_reg < best_sector_reg));
        case (cmd_reg.func)
            FUNC_ADD:      take = !p1_live_reg && !found_reg;
            FUNC_REMOVE:   take = p1_live_reg && (p1_tag_reg == cmd_reg.tag) && !found_reg;
            FUNC_DISPATCH: take = p1_live_reg && better;
            default:       take = 1'b0;
        endcase
        take = take && p1_act_reg;
    end

    // datapath
    always_comb
    begin
        cmd_next         = cmd_reg;
        head_next        = head_reg;
        valid_next       = valid_reg;
        rd_cnt_next      = rd_cnt_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_dist_next   = best_dist_reg;
        best_sector_next = best_sector_reg;
        best_tag_next    = best_tag_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_sector_next  = out_sector_reg;
        out_tag_next     = out_tag_reg;

        p0_act_next      = issue;
        p0_idx_next      = rd_cnt_reg[IDX_BITS-1:0];
        p0_live_next     = valid_reg[rd_cnt_reg[IDX_BITS-1:0]];

        p1_act_next      = p0_act_reg;
        p1_idx_next      = p0_idx_reg;
        p1_live_next     = p0_live_reg;
        p1_sector_next   = rd_sector;
        p1_tag_next      = rd_tag;
        p1_dist_next     = (rd_sector >= head_reg) ? (rd_sector - head_reg)
                         : (head_reg - rd_sector);

        if (cmd_valid && cmd_ready)
        begin
            cmd_next    = cmd;
            rd_cnt_next = '0;
            found_next  = 1'b0;
        end

        if (issue)
        begin
            rd_cnt_next = rd_cnt_reg + 1'b1;
        end

        if (take)
        begin
            found_next       = 1'b1;
            best_idx_next    = p1_idx_reg;
            best_dist_next   = p1_dist_reg;
            best_sector_next = p1_sector_reg;
            best_tag_next    = p1_tag_reg;
        end

        if (commit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_sector_next = '0;
            out_tag_next    = '0;
            case (cmd_reg.func)
                FUNC_ADD:
                begin
                    if (found_reg)
                    begin
                        valid_next[best_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        out_status_next = ST_FULL;
                    end
                end
                FUNC_REMOVE:
                begin
                    if (found_reg)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        out_status_next = ST_NOTFOUND;
                    end
                end
                FUNC_DISPATCH:
                begin
                    if (found_reg)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                        head_next                = best_sector_reg;
                        out_sector_next          = best_sector_reg;
                        out_tag_next             = best_tag_reg;
                    end
                    else
                    begin
                        out_status_next = ST_EMPTY;
                    end
                end
                default:
                begin
                    out_status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= '1;
            valid_reg     <= '0;
            rd_cnt_reg    <= '0;
            p0_act_reg    <= 1'b0;
            p1_act_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            valid_reg     <= valid_next;
            rd_cnt_reg    <= rd_cnt_next;
            p0_act_reg    <= p0_act_next;
            p1_act_reg    <= p1_act_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        p0_idx_reg      <= p0_idx_next;
        p0_live_reg     <= p0_live_next;
        p1_idx_reg      <= p1_idx_next;
        p1_live_reg     <= p1_live_next;
        p1_dist_reg     <= p1_dist_next;
        p1_sector_reg   <= p1_sector_next;
        p1_tag_reg      <= p1_tag_next;
        best_idx_reg    <= best_idx_next;
        best_dist_reg   <= best_dist_next;
        best_sector_reg <= best_sector_next;
        best_tag_reg    <= best_tag_next;
        out_status_reg  <= out_status_next;
        out_sector_reg  <= out_sector_next;
        out_tag_reg     <= out_tag_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.out_sector = out_sector_reg;
    assign rsp.out_tag    = out_tag_reg;

    // scan pipeline drains before the command is committed
    a_drain_before_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN) && p1_act_reg |=> (state_reg == BK_SCAN))
        else $error("scan left with compare stage busy");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_IDLE) |-> !p0_act_reg && !p1_act_reg)
        else $error("scan pipeline busy while idle");

    a_dispatch_moves_head: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (cmd_reg.func == FUNC_DISPATCH) && found_reg
        |=> (head_reg == $past(best_sector_reg)))
        else $error("head position not moved to dispatched sector");

    a_add_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (cmd_reg.func == FUNC_ADD) && found_reg
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("add did not occupy exactly one slot");

endmodule
`default_nettype wire

>>> sv/sstf_request_scheduler.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sstf_request_scheduler
// shortest seek time first disk request queue
// ---------------------------------------------------------------------------
// req carries one command per transfer: add (sector, tag), dispatch nearest,
// or remove by tag. rsp returns one transfer per command with status, and
// for a successful dispatch the sector and tag of the chosen request.
// commands enter a two-entry queue, then a scan engine walks every slot of
// the slot ram once, one slot per cycle, through a read / distance / compare
// pipeline, a pace set by the single read port of the slot ram. a nop skips
// the scan. reset empties all slots and sets the head position to all ones;
// slot contents are not cleared. when the receiver stalls, the result holds
// in the output register, the scan engine finishes one more command and
// waits, the queue takes two more, and req.ready then drops until the result
// is taken.
// ---------------------------------------------------------------------------
module sstf_request_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    sstf_req_if.sink   req,
    sstf_rsp_if.source rsp
);
    import sstf_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    sstf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    sstf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire
